/* design/nsa_pkg.sv */
// Package: shared types and constants for the nearest server assignment unit.
package nsa_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W = 4;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [19:0] BASE_FARE = 20'd12800;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_NOSPEED = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SQRT, S_DIV, S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start_scan;
		logic scan_step;
		logic start_sqrt;
		logic sqrt_step;
		logic start_div;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic sqrt_last;
		logic div_last;
		logic found;
	} sts_t;
endpackage

/* design/nsa_ctrl.sv */
// Controller: issues table loads, and sequences scan, square root and division for each request item.
module nsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           in_cmd,
	input  logic           out_busy,
	input  nsa_pkg::sts_t  sts,
	output nsa_pkg::cmd_t  cmd,
	output logic           ready
);
	nsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= nsa_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		ready = 1'b0;
		case (state_q)
			nsa_pkg::S_IDLE: begin
				ready = 1'b1;
				if (in_fire) begin
					if (in_cmd) begin
						cmd.start_scan = 1'b1;
						state_d = nsa_pkg::S_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			nsa_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = nsa_pkg::S_SQRT;
			end
			nsa_pkg::S_SQRT: begin
				if (!sts.found) begin
					state_d = nsa_pkg::S_OUT;
				end else begin
					cmd.sqrt_step = 1'b1;
					if (sts.sqrt_last) state_d = nsa_pkg::S_DIV;
				end
			end
			nsa_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = nsa_pkg::S_OUT;
			end
			nsa_pkg::S_OUT: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = nsa_pkg::S_IDLE;
				end
			end
			default: state_d = nsa_pkg::S_IDLE;
		endcase
		cmd.start_sqrt = (state_q == nsa_pkg::S_SCAN) && sts.scan_last;
		cmd.start_div = (state_q == nsa_pkg::S_SQRT) && sts.sqrt_last;
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> state_q == nsa_pkg::S_IDLE) else $error("ready outside idle");
	a_scan_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_scan |=> state_q == nsa_pkg::S_SCAN) else $error("scan not entered");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == nsa_pkg::S_IDLE) else $error("finish not idle");
`endif
endmodule

/* design/nsa_dp.sv */
// Datapath: server table, distance scan, square root, divider and result register.
module nsa_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nsa_pkg::cmd_t        cmd,
	output nsa_pkg::sts_t        sts,
	input  logic [3:0]           in_slot,
	input  logic [15:0]          in_id,
	input  logic signed [15:0]   in_x,
	input  logic signed [15:0]   in_y,
	input  logic [7:0]           in_speed,
	input  logic                 out_take,
	output logic                 out_valid,
	output logic [1:0]           status,
	output logic [15:0]          chosen_id,
	output logic [16:0]          distance,
	output logic [19:0]          fare,
	output logic [22:0]          arrival_minutes
);
	logic [nsa_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [15:0] id_mem [nsa_pkg::TABLE_DEPTH];
	logic signed [15:0] x_mem [nsa_pkg::TABLE_DEPTH];
	logic signed [15:0] y_mem [nsa_pkg::TABLE_DEPTH];
	logic [7:0] sp_mem [nsa_pkg::TABLE_DEPTH];

	logic signed [15:0] rx_q, ry_q;
	logic [nsa_pkg::IDX_W:0] idx_q;
	logic found_q;
	logic [nsa_pkg::IDX_W-1:0] best_q;
	logic [33:0] bd2_q;
	logic [15:0] bid_q;
	logic [7:0] bsp_q;

	logic [33:0] rem_q;
	logic [16:0] root_q;
	logic [4:0] sq_q;
	logic [22:0] dnum_q;
	logic [22:0] quo_q;
	logic [7:0] drem_q;
	logic [4:0] dv_q;

	logic [nsa_pkg::IDX_W-1:0] ci;
	logic signed [16:0] dx, dy;
	logic signed [33:0] dxw, dyw;
	logic [33:0] dxx, dyy;
	logic [33:0] d2;
	logic cand;
	assign ci = idx_q[nsa_pkg::IDX_W-1:0];
	assign dx = 17'(x_mem[ci]) - 17'(rx_q);
	assign dy = 17'(y_mem[ci]) - 17'(ry_q);
	assign dxw = 34'(dx);
	assign dyw = 34'(dy);
	assign dxx = $unsigned(dxw * dxw);
	assign dyy = $unsigned(dyw * dyw);
	assign d2 = dxx + dyy;
	assign cand = valid_q[ci] && (!found_q || d2 < bd2_q ||
		(d2 == bd2_q && id_mem[ci] < bid_q));

	logic [35:0] trial;
	logic [16:0] root_nx;
	logic [8:0] dtrial;
	assign trial = {rem_q, bd2_q[33:32]} - 36'({root_q, 2'b01});
	assign root_nx = {root_q[15:0], !trial[35]};
	assign dtrial = {drem_q, dnum_q[22]} - {1'b0, bsp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load && 32'(in_slot) < nsa_pkg::TABLE_DEPTH)
				valid_q[in_slot[nsa_pkg::IDX_W-1:0]] <= 1'b1;
			if (cmd.finish) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && 32'(in_slot) < nsa_pkg::TABLE_DEPTH) begin
			id_mem[in_slot[nsa_pkg::IDX_W-1:0]] <= in_id;
			x_mem[in_slot[nsa_pkg::IDX_W-1:0]] <= in_x;
			y_mem[in_slot[nsa_pkg::IDX_W-1:0]] <= in_y;
			sp_mem[in_slot[nsa_pkg::IDX_W-1:0]] <= in_speed;
		end
		if (cmd.start_scan) begin
			rx_q <= in_x;
			ry_q <= in_y;
			idx_q <= '0;
			found_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cand) begin
				found_q <= 1'b1;
				best_q <= ci;
				bd2_q <= d2;
				bid_q <= id_mem[ci];
				bsp_q <= sp_mem[ci];
			end
		end
		if (cmd.start_sqrt) begin
			rem_q <= '0;
			root_q <= '0;
			sq_q <= '0;
		end
		if (cmd.sqrt_step) begin
			sq_q <= sq_q + 1'b1;
			bd2_q <= {bd2_q[31:0], 2'b00};
			root_q <= root_nx;
			if (!trial[35])
				rem_q <= trial[33:0];
			else
				rem_q <= {rem_q[31:0], bd2_q[33:32]};
		end
		if (cmd.start_div) begin
			dnum_q <= 23'(root_nx) * 23'd60;
			quo_q <= '0;
			drem_q <= '0;
			dv_q <= '0;
		end
		if (cmd.div_step) begin
			dv_q <= dv_q + 1'b1;
			dnum_q <= {dnum_q[21:0], 1'b0};
			if (!dtrial[8]) begin
				drem_q <= dtrial[7:0];
				quo_q <= {quo_q[21:0], 1'b1};
			end else begin
				drem_q <= {drem_q[6:0], dnum_q[22]};
				quo_q <= {quo_q[21:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (!found_q) begin
				status <= nsa_pkg::ST_EMPTY;
				chosen_id <= '0;
				distance <= '0;
				fare <= '0;
				arrival_minutes <= '0;
			end else begin
				status <= (bsp_q == 8'd0) ? nsa_pkg::ST_NOSPEED : nsa_pkg::ST_OK;
				chosen_id <= bid_q;
				distance <= root_q;
				fare <= nsa_pkg::BASE_FARE + 20'({root_q, 3'b000}) + 20'({root_q, 1'b0});
				arrival_minutes <= (bsp_q == 8'd0) ? 23'd0 : quo_q;
				x_mem[best_q] <= rx_q;
				y_mem[best_q] <= ry_q;
			end
		end
	end

	assign sts.scan_last = (idx_q == (nsa_pkg::IDX_W+1)'(nsa_pkg::TABLE_DEPTH - 1));
	assign sts.sqrt_last = (sq_q == 5'd16);
	assign sts.div_last = (dv_q == 5'd22);
	assign sts.found = found_q;

`ifndef ASSERT_OFF
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && status == nsa_pkg::ST_EMPTY |-> chosen_id == 16'd0)
		else $error("empty result not zero");
	a_fare: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && status != nsa_pkg::ST_EMPTY |->
		fare == nsa_pkg::BASE_FARE + 20'(distance) * 20'd10) else $error("fare mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_take |=> out_valid) else $error("result dropped");
`endif
endmodule

/* design/nearest_server_assignment_unit.sv */
// Top level: nearest server assignment unit.
// Input channel s_axis carries load items (tuser 0) and request items
// (tuser 1). A load writes one table slot and returns nothing, and loads
// can be accepted back to back. A request scans all 16 slots (one per
// cycle), runs a 17-step bit-pair square root of the best squared
// distance and a 23-step restoring divide for the arrival time, then
// places one result item on m_axis and moves the found server to the
// request position. A request passes through the scan, root, divide and
// output states in that order; the next item is accepted only once the
// block is back in idle. An empty table skips root and divide.
// Results sit in an output register; s_axis_tready is high only while idle,
// and when m_axis is stalled the block waits in its output state until the
// previous result is taken. Reset clears all valid bits and the output
// valid flag.
module nearest_server_assignment_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// slot, server_id, pos_x, pos_y, speed, 4 zero bits
	input  logic [63:0] s_axis_tdata,
	// command
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, chosen_id, distance, fare, arrival_minutes, 2 zero bits
	output logic [79:0] m_axis_tdata
);
	nsa_pkg::cmd_t cmd;
	nsa_pkg::sts_t sts;
	logic in_fire;
	logic [1:0] status;
	logic [15:0] chosen_id;
	logic [16:0] distance;
	logic [19:0] fare;
	logic [22:0] arrival_minutes;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	nsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_cmd(s_axis_tuser),
		.out_busy(m_axis_tvalid && !m_axis_tready), .sts(sts), .cmd(cmd),
		.ready(s_axis_tready)
	);

	nsa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_slot(s_axis_tdata[3:0]), .in_id(s_axis_tdata[19:4]),
		.in_x(s_axis_tdata[35:20]), .in_y(s_axis_tdata[51:36]),
		.in_speed(s_axis_tdata[59:52]),
		.out_take(m_axis_tready), .out_valid(m_axis_tvalid),
		.status(status), .chosen_id(chosen_id), .distance(distance),
		.fare(fare), .arrival_minutes(arrival_minutes)
	);

	assign m_axis_tdata = {2'b00, arrival_minutes, fare, distance, chosen_id, status};
endmodule
